### design/tag_presence_miss_monitor_assert.svh
// Assertion macros for the tag presence miss monitor.
`ifndef TAG_PRESENCE_MISS_MONITOR_ASSERT_SVH
`define TAG_PRESENCE_MISS_MONITOR_ASSERT_SVH

`ifndef SYNTHESIS

`define TPMM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TPMM_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define TPMM_ASSERT_IMP(lbl, ante, cons, msg)

`define TPMM_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

### design/tpmm_pkg.sv
`default_nettype none

package tpmm_pkg;

    localparam int TAG_COUNT    = 256;
    localparam int TAG_IDX_W    = $clog2(TAG_COUNT);
    localparam int TAG_W        = 8;
    localparam int DATA_W       = 8;
    localparam int PACKET_BYTES = 32;
    localparam int COUNT_W      = 16;
    localparam int POS_W        = 6;
    localparam int CNT_W        = 9;
    localparam int SCAN_W       = $clog2(TAG_COUNT + 1);
    localparam int MS_W         = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam logic [31:0] WINDOW_MS_RESET = 32'd10000;

    typedef enum logic [1:0] {
        FUNC_BYTE  = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_COUNTED = 2'd1,
        KIND_CLOSED  = 2'd2,
        KIND_QUERY   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_INVALID = 2'd0,
        OP_PACKET  = 2'd1,
        OP_QUERY   = 2'd2
    } op_t;

    typedef enum logic [0:0] {
        CFG_WINDOW_MS    = 1'b0,
        CFG_ALARM_ENABLE = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QUERY,
        ST_PACKET,
        ST_SCAN
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [TAG_W-1:0] tag;
        logic             close;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] wh;
        logic [COUNT_W-1:0] ch;
        logic               missed;
        logic               alarm;
    } entry_t;

    typedef struct packed {
        kind_t              kind;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] hits;
        logic               seen;
        logic               missed;
        logic               alarmed;
        logic [CNT_W-1:0]   mcount;
        logic [CNT_W-1:0]   acount;
        logic               led;
    } result_t;

endpackage

`default_nettype wire

### design/tag_presence_miss_monitor.sv
// Tag presence miss monitor. Items go in through push/full and results come out through
// empty/pop, both sides decoupled by two-entry queues. Payload bytes, ticks and ignored
// codes are handled in the front end and produce no result. An invalid packet passes
// through the command queue, and its result is pushed in the same cycle that the back end
// takes its command. A query or a counted packet takes its command, reads the per-tag
// table, then pushes the result, with the table write-back for a packet. A packet that
// closes the window scans all 256 table entries through the single read port, one a
// cycle, and its result is pushed once the scan is done. Later items wait in the command
// queue meanwhile, and full rises once it fills. The per-tag table is cleared at reset
// through its seen bits, with no clearing pass.
`default_nettype none

`include "tag_presence_miss_monitor_assert.svh"

module tag_presence_miss_monitor (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [1:0]                   func,
    input  wire logic [tpmm_pkg::DATA_W-1:0]  data,
    input  wire logic                         last_byte,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [1:0]                        kind,
    output logic [tpmm_pkg::TAG_W-1:0]        tag,
    output logic [tpmm_pkg::COUNT_W-1:0]      hits,
    output logic                              seen,
    output logic                              missed,
    output logic                              alarmed,
    output logic [tpmm_pkg::CNT_W-1:0]        missed_count,
    output logic [tpmm_pkg::CNT_W-1:0]        new_alarm_count,
    output logic                              led2_level,
    input  wire logic                         cfg_we,
    input  wire logic [0:0]                   cfg_addr,
    input  wire logic [31:0]                  cfg_data
);

    logic [tpmm_pkg::MS_W-1:0]     window_ms_reg;
    logic                          alarm_enable_reg;
    logic                          in_accept;
    logic                          cmd_push, cmd_pop, cmd_vld;
    tpmm_pkg::cmd_t                cmd_in, cmd_out;
    logic                          res_push, res_ready, res_pop;
    tpmm_pkg::result_t             res_in, res_out;
    logic                          led_level;
    tpmm_pkg::result_t             res_mem_reg [tpmm_pkg::QUEUE_DEPTH];
    logic [tpmm_pkg::QPTR_W-1:0]   res_wr_reg, res_rd_reg;
    logic [tpmm_pkg::QCNT_W-1:0]   res_cnt_reg, res_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg    <= tpmm_pkg::WINDOW_MS_RESET;
            alarm_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (tpmm_pkg::cfg_idx_t'(cfg_addr))
                tpmm_pkg::CFG_WINDOW_MS:    window_ms_reg    <= cfg_data;
                tpmm_pkg::CFG_ALARM_ENABLE: alarm_enable_reg <= cfg_data[0];
            endcase
        end
    end

    assign in_accept = push && !full;

    tpmm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .func      (func),
        .data      (data),
        .last_byte (last_byte),
        .window_ms (window_ms_reg),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    tpmm_cmd_queue u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .vld   (cmd_vld),
        .full  (full)
    );

    tpmm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_vld      (cmd_vld),
        .cmd          (cmd_out),
        .cmd_pop      (cmd_pop),
        .alarm_enable (alarm_enable_reg),
        .res_ready    (res_ready),
        .res_push     (res_push),
        .res          (res_in),
        .led_level    (led_level)
    );

    always_comb
    begin
        res_ready    = res_cnt_reg != tpmm_pkg::QCNT_W'(tpmm_pkg::QUEUE_DEPTH);
        empty        = res_cnt_reg == '0;
        res_pop      = pop && !empty;
        res_out      = res_mem_reg[res_rd_reg];
        res_cnt_next = res_cnt_reg;
        if (res_push && !res_pop)
            res_cnt_next = res_cnt_reg + tpmm_pkg::QCNT_W'(1);
        else if (res_pop && !res_push)
            res_cnt_next = res_cnt_reg - tpmm_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            res_cnt_reg <= res_cnt_next;
            if (res_push)
                res_wr_reg <= res_wr_reg + tpmm_pkg::QPTR_W'(1);
            if (res_pop)
                res_rd_reg <= res_rd_reg + tpmm_pkg::QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            res_mem_reg[res_wr_reg] <= res_in;
    end

    assign kind            = res_out.kind;
    assign tag             = res_out.tag;
    assign hits            = res_out.hits;
    assign seen            = res_out.seen;
    assign missed          = res_out.missed;
    assign alarmed         = res_out.alarmed;
    assign missed_count    = res_out.mcount;
    assign new_alarm_count = res_out.acount;
    assign led2_level      = res_out.led;

    `TPMM_ASSERT_IMP(a_cmd_pop_vld, cmd_pop, cmd_vld, "command taken from empty queue")
    `TPMM_ASSERT_IMP(a_res_room, res_push, res_ready, "result transfer into full queue")
    `TPMM_ASSERT_IMP(a_led_close, !$stable(led_level),
        $past(res_push && res_in.kind == tpmm_pkg::KIND_CLOSED), "LED moved without window close")
    `TPMM_ASSERT_NEVER(a_close_counts, res_push && res_in.kind != tpmm_pkg::KIND_CLOSED
        && (res_in.mcount != '0 || res_in.acount != '0), "counts outside window close")

endmodule

`default_nettype wire

### design/tpmm_front.sv
`default_nettype none

module tpmm_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [1:0]                func,
    input  wire logic [tpmm_pkg::DATA_W-1:0] data,
    input  wire logic                      last_byte,
    input  wire logic [tpmm_pkg::MS_W-1:0] window_ms,
    output logic                           cmd_push,
    output tpmm_pkg::cmd_t                 cmd
);

    logic [tpmm_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       good_reg, good_next;
    logic [tpmm_pkg::MS_W-1:0]  ms_now_reg, ms_now_next;
    logic [tpmm_pkg::MS_W-1:0]  start_reg, start_next;
    logic [tpmm_pkg::MS_W-1:0]  elapsed;
    logic [tpmm_pkg::DATA_W-1:0] expect_byte;
    logic                       tag_ok;
    logic                       valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            good_reg   <= 1'b1;
            ms_now_reg <= '0;
            start_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            good_reg   <= good_next;
            ms_now_reg <= ms_now_next;
            start_reg  <= start_next;
        end
    end

    always_comb
    begin
        elapsed     = ms_now_reg - start_reg;
        expect_byte = tpmm_pkg::DATA_W'({2'b00, pos_reg}) + tpmm_pkg::DATA_W'(1);
        tag_ok      = {1'b0, data} < (tpmm_pkg::TAG_W + 1)'(tpmm_pkg::TAG_COUNT);
        valid       = good_reg && (pos_reg == tpmm_pkg::POS_W'(tpmm_pkg::PACKET_BYTES - 1))
                      && tag_ok;
        pos_next    = pos_reg;
        good_next   = good_reg;
        ms_now_next = ms_now_reg;
        start_next  = start_reg;
        cmd_push    = 1'b0;
        cmd.op      = tpmm_pkg::OP_INVALID;
        cmd.tag     = data;
        cmd.close   = 1'b0;
        if (accept)
        begin
            unique case (tpmm_pkg::func_t'(func))
                tpmm_pkg::FUNC_TICK:
                begin
                    ms_now_next = ms_now_reg + tpmm_pkg::MS_W'(1);
                end
                tpmm_pkg::FUNC_QUERY:
                begin
                    cmd_push = 1'b1;
                    cmd.op   = tpmm_pkg::OP_QUERY;
                end
                tpmm_pkg::FUNC_BYTE:
                begin
                    if (!last_byte)
                    begin
                        if (pos_reg >= tpmm_pkg::POS_W'(tpmm_pkg::PACKET_BYTES - 1)
                            || data != expect_byte)
                            good_next = 1'b0;
                        if (pos_reg != '1)
                            pos_next = pos_reg + tpmm_pkg::POS_W'(1);
                    end
                    else
                    begin
                        pos_next  = '0;
                        good_next = 1'b1;
                        cmd_push  = 1'b1;
                        if (valid)
                        begin
                            cmd.op = tpmm_pkg::OP_PACKET;
                            if (elapsed > window_ms)
                            begin
                                cmd.close  = 1'b1;
                                start_next = ms_now_reg;
                            end
                        end
                    end
                end
                tpmm_pkg::FUNC_NONE:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/tpmm_cmd_queue.sv
`default_nettype none

module tpmm_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  tpmm_pkg::cmd_t      din,
    input  wire logic           pop,
    output tpmm_pkg::cmd_t      dout,
    output logic                vld,
    output logic                full
);

    tpmm_pkg::cmd_t                mem_reg [tpmm_pkg::QUEUE_DEPTH];
    logic [tpmm_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [tpmm_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        vld  = cnt_reg != '0;
        full = cnt_reg == tpmm_pkg::QCNT_W'(tpmm_pkg::QUEUE_DEPTH);
        dout = mem_reg[rd_ptr_reg];
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + tpmm_pkg::QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - tpmm_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + tpmm_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + tpmm_pkg::QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

`default_nettype wire

### design/tpmm_back.sv
`default_nettype none

module tpmm_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_vld,
    input  tpmm_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    input  wire logic           alarm_enable,
    input  wire logic           res_ready,
    output logic                res_push,
    output tpmm_pkg::result_t   res,
    output logic                led_level
);

    tpmm_pkg::state_t                 state_reg, state_next;
    logic [tpmm_pkg::TAG_COUNT-1:0]   seen_vec_reg;
    tpmm_pkg::entry_t                 mem [tpmm_pkg::TAG_COUNT];
    tpmm_pkg::entry_t                 rd_data_reg;
    logic                             seen_rd_reg;
    logic [tpmm_pkg::TAG_W-1:0]       tag_reg, tag_next;
    logic                             qry_ok_reg, qry_ok_next;
    logic                             close_reg, close_next;
    logic [tpmm_pkg::COUNT_W-1:0]     live_reg, live_next;
    logic                             alarm_t_reg, alarm_t_next;
    logic [tpmm_pkg::SCAN_W-1:0]      scan_rd_reg, scan_rd_next;
    logic                             proc_vld_reg, proc_vld_next;
    logic [tpmm_pkg::CNT_W-1:0]       mcount_reg, mcount_next;
    logic [tpmm_pkg::CNT_W-1:0]       acount_reg, acount_next;
    logic                             led_reg, led_next;

    logic                             rd_en, wr_en, set_seen;
    logic [tpmm_pkg::TAG_IDX_W-1:0]   rd_addr, wr_addr;
    tpmm_pkg::entry_t                 wr_data, ent;
    logic [tpmm_pkg::COUNT_W-1:0]     live;
    logic                             miss;

    assign led_level = led_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tpmm_pkg::ST_IDLE;
            proc_vld_reg <= 1'b0;
            led_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            proc_vld_reg <= proc_vld_next;
            led_reg      <= led_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg     <= tag_next;
        qry_ok_reg  <= qry_ok_next;
        close_reg   <= close_next;
        live_reg    <= live_next;
        alarm_t_reg <= alarm_t_next;
        scan_rd_reg <= scan_rd_next;
        mcount_reg  <= mcount_next;
        acount_reg  <= acount_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_vec_reg <= '0;
        else if (set_seen)
            seen_vec_reg[tag_reg[tpmm_pkg::TAG_IDX_W-1:0]] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            seen_rd_reg <= seen_vec_reg[rd_addr];
        end
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_comb
    begin
        ent  = seen_rd_reg ? rd_data_reg : '0;
        live = (ent.wh == '1) ? ent.wh : ent.wh + tpmm_pkg::COUNT_W'(1);
        miss = rd_data_reg.wh == '0;

        state_next    = state_reg;
        tag_next      = tag_reg;
        qry_ok_next   = qry_ok_reg;
        close_next    = close_reg;
        live_next     = live_reg;
        alarm_t_next  = alarm_t_reg;
        scan_rd_next  = scan_rd_reg;
        proc_vld_next = proc_vld_reg;
        mcount_next   = mcount_reg;
        acount_next   = acount_reg;
        led_next      = led_reg;
        cmd_pop       = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = tag_reg[tpmm_pkg::TAG_IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = tag_reg[tpmm_pkg::TAG_IDX_W-1:0];
        wr_data       = ent;
        set_seen      = 1'b0;
        res_push      = 1'b0;
        res           = '0;
        res.tag       = tag_reg;
        res.led       = led_reg;

        unique case (state_reg)
            tpmm_pkg::ST_IDLE:
            begin
                if (cmd_vld && res_ready)
                begin
                    cmd_pop     = 1'b1;
                    tag_next    = cmd.tag;
                    close_next  = cmd.close;
                    qry_ok_next = {1'b0, cmd.tag}
                                  < (tpmm_pkg::TAG_W + 1)'(tpmm_pkg::TAG_COUNT);
                    rd_addr     = cmd.tag[tpmm_pkg::TAG_IDX_W-1:0];
                    unique case (cmd.op)
                        tpmm_pkg::OP_INVALID:
                        begin
                            res_push = 1'b1;
                            res.kind = tpmm_pkg::KIND_INVALID;
                            res.tag  = cmd.tag;
                        end
                        tpmm_pkg::OP_QUERY:
                        begin
                            rd_en      = qry_ok_next;
                            state_next = tpmm_pkg::ST_QUERY;
                        end
                        tpmm_pkg::OP_PACKET:
                        begin
                            rd_en      = 1'b1;
                            state_next = tpmm_pkg::ST_PACKET;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tpmm_pkg::ST_QUERY:
            begin
                res_push = 1'b1;
                res.kind = tpmm_pkg::KIND_QUERY;
                if (qry_ok_reg)
                begin
                    res.hits    = ent.ch;
                    res.seen    = seen_rd_reg;
                    res.missed  = ent.missed;
                    res.alarmed = ent.alarm;
                end
                state_next = tpmm_pkg::ST_IDLE;
            end
            tpmm_pkg::ST_PACKET:
            begin
                wr_en      = 1'b1;
                wr_data.wh = live;
                set_seen   = 1'b1;
                if (!close_reg)
                begin
                    res_push    = 1'b1;
                    res.kind    = tpmm_pkg::KIND_COUNTED;
                    res.hits    = live;
                    res.seen    = 1'b1;
                    res.missed  = ent.missed;
                    res.alarmed = ent.alarm;
                    state_next  = tpmm_pkg::ST_IDLE;
                end
                else
                begin
                    live_next     = live;
                    alarm_t_next  = ent.alarm;
                    scan_rd_next  = '0;
                    proc_vld_next = 1'b0;
                    mcount_next   = '0;
                    acount_next   = '0;
                    state_next    = tpmm_pkg::ST_SCAN;
                end
            end
            tpmm_pkg::ST_SCAN:
            begin
                // issue one read a cycle, retire the entry read last cycle
                if (scan_rd_reg != tpmm_pkg::SCAN_W'(tpmm_pkg::TAG_COUNT))
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_rd_reg[tpmm_pkg::TAG_IDX_W-1:0];
                    scan_rd_next  = scan_rd_reg + tpmm_pkg::SCAN_W'(1);
                    proc_vld_next = 1'b1;
                end
                else
                    proc_vld_next = 1'b0;
                wr_addr = scan_rd_reg[tpmm_pkg::TAG_IDX_W-1:0]
                          - tpmm_pkg::TAG_IDX_W'(1);
                if (proc_vld_reg && seen_rd_reg)
                begin
                    wr_en          = 1'b1;
                    wr_data.wh     = '0;
                    wr_data.ch     = rd_data_reg.wh;
                    wr_data.missed = miss;
                    wr_data.alarm  = rd_data_reg.alarm | miss;
                    if (miss)
                    begin
                        mcount_next = mcount_reg + tpmm_pkg::CNT_W'(1);
                        if (alarm_enable && !rd_data_reg.alarm)
                            acount_next = acount_reg + tpmm_pkg::CNT_W'(1);
                    end
                end
                if (scan_rd_reg == tpmm_pkg::SCAN_W'(tpmm_pkg::TAG_COUNT) && !proc_vld_reg)
                begin
                    led_next    = led_reg ^ (mcount_reg != '0);
                    res_push    = 1'b1;
                    res.kind    = tpmm_pkg::KIND_CLOSED;
                    res.hits    = live_reg;
                    res.seen    = 1'b1;
                    res.alarmed = alarm_t_reg;
                    res.mcount  = mcount_reg;
                    res.acount  = acount_reg;
                    res.led     = led_next;
                    state_next  = tpmm_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire
